// ===== rtl/fade_alpha_ramp_timer_top_assert.svh =====
// assertion macros for the fade alpha ramp timer
`ifndef FADE_ALPHA_RAMP_TIMER_TOP_ASSERT_SVH
`define FADE_ALPHA_RAMP_TIMER_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define FDR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define FDR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/fdramp_pkg.sv =====
// package for the fade alpha ramp timer: widths, codes, sequencer states, alu types
`timescale 1ns / 1ps
`default_nettype none

package fdramp_pkg;

  localparam int TIME_W  = 16;
  localparam int ELAP_W  = TIME_W + 4;
  localparam int RAMP_W  = TIME_W + 2;
  localparam int ALPHA_W = 8;
  localparam int REM_W   = RAMP_W + ALPHA_W;
  localparam int DIV_W   = RAMP_W + ALPHA_W - 1;
  localparam int ALU_W   = REM_W + 1;
  localparam int CNT_W   = $clog2(ALPHA_W);

  localparam logic [ALPHA_W:0]   NO_ALPHA  = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_MAX = '1;
  localparam logic [ALPHA_W-1:0] ALPHA_MIN = '0;

  localparam logic [1:0] MODE_IN    = 2'd0;
  localparam logic [1:0] MODE_OUT   = 2'd1;
  localparam logic [1:0] MODE_OUTIN = 2'd2;
  localparam logic [1:0] MODE_NONE  = 2'd3;

  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_FADE  = 2'd1;
  localparam logic [1:0] REG_DARK  = 2'd2;
  localparam logic [1:0] REG_SPARE = 2'd3;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK  = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ELAP,
    ST_RAMP,
    ST_TOT,
    ST_CMP,
    ST_PH1,
    ST_PH2,
    ST_NUM,
    ST_CLAMP,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } st_t;

  typedef struct packed {
    logic [ALU_W-1:0] a;
    logic [ALU_W-1:0] b;
    logic             sub;
  } alu_req_t;

  typedef struct packed {
    logic [ALU_W-1:0] val;
    logic             carry;
    logic             borrow;
  } alu_res_t;

endpackage

`default_nettype wire

// ===== rtl/fdramp_alu.sv =====
// shared add / subtract-compare unit of the fade timer
`timescale 1ns / 1ps
`default_nettype none

module fdramp_alu (
  input  wire fdramp_pkg::alu_req_t req,
  output fdramp_pkg::alu_res_t      res
);

  logic [fdramp_pkg::ALU_W-1:0] b_eff;
  logic [fdramp_pkg::ALU_W:0]   full;

  always_comb begin
    b_eff      = req.sub ? ~req.b : req.b;
    full       = {1'b0, req.a} + {1'b0, b_eff} + {{fdramp_pkg::ALU_W{1'b0}}, req.sub};
    res.val    = full[fdramp_pkg::ALU_W-1:0];
    res.carry  = full[fdramp_pkg::ALU_W];
    // a - b borrows when there is no carry out
    res.borrow = req.sub & ~full[fdramp_pkg::ALU_W];
  end

endmodule

`default_nettype wire

// ===== rtl/fade_alpha_ramp_timer_top.sv =====
// fade alpha ramp timer top level: config registers, sequencer and result register
//
// Input channel (in_valid / in_stall): in_req_type start (0) or tick (1),
// in_delta_ticks is the tick length. One result per transaction on the output
// channel (out_valid / out_stall): out_alpha, out_alpha_updated, out_active.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 fade_mode, 1 fade_time, 2 darken_time); write only while the block is idle.
// A tick while not running goes straight to the result register; for a start or
// running tick the single shared add/subtract unit does the elapsed update (ticks
// only), ramp, total, phase compares, 255*num and eight restoring divide steps for
// alpha = floor(255*num/ramp). out_valid rises as a result enters the output register.
// One item at a time: in_stall is high from acceptance until the result is
// moved into the output register, so no new item is taken before then.
// A finished result waits in the output register while out_stall is high; the
// next item is still accepted, but its result is held back until the slot frees.
// Reset clears the config registers, elapsed time and running flag, and marks
// that no alpha has been produced yet (held alpha reads as 0).
`timescale 1ns / 1ps
`default_nettype none

module fade_alpha_ramp_timer_top (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               cfg_we,
  input  wire  [1:0]                        cfg_index,
  input  wire  [fdramp_pkg::TIME_W-1:0]     cfg_data,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire                               in_req_type,
  input  wire  [fdramp_pkg::TIME_W-1:0]     in_delta_ticks,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [fdramp_pkg::ALPHA_W-1:0]    out_alpha,
  output logic                              out_alpha_updated,
  output logic                              out_active
);

`include "fade_alpha_ramp_timer_top_assert.svh"

  localparam int TW = fdramp_pkg::TIME_W;
  localparam int EW = fdramp_pkg::ELAP_W;
  localparam int RW = fdramp_pkg::RAMP_W;
  localparam int AW = fdramp_pkg::ALPHA_W;
  localparam int XW = fdramp_pkg::REM_W;
  localparam int DW = fdramp_pkg::DIV_W;
  localparam int UW = fdramp_pkg::ALU_W;
  localparam int CW = fdramp_pkg::CNT_W;

  // configuration registers
  logic [1:0]    fade_mode_r;
  logic [TW-1:0] fade_time_r;
  logic [TW-1:0] darken_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_mode_r   <= fdramp_pkg::MODE_IN;
      fade_time_r   <= '0;
      darken_time_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fdramp_pkg::REG_MODE:  fade_mode_r   <= cfg_data[1:0];
        fdramp_pkg::REG_FADE:  fade_time_r   <= cfg_data;
        fdramp_pkg::REG_DARK:  darken_time_r <= cfg_data;
        fdramp_pkg::REG_SPARE: ;
        default: ;
      endcase
    end
  end

  fdramp_pkg::st_t state_r, state_nxt;

  logic          running_r, running_nxt;
  logic [EW-1:0] elapsed_r, elapsed_nxt;
  logic [AW:0]   last_alpha_r, last_alpha_nxt;

  logic [TW-1:0] delta_r, delta_nxt;
  logic [RW-1:0] ramp_r, ramp_nxt;
  logic [EW-1:0] acc_r, acc_nxt;
  logic [EW-1:0] num_r, num_nxt;
  logic [XW-1:0] rem_r, rem_nxt;
  logic [DW-1:0] div_r, div_nxt;
  logic [AW-2:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          fadein_r, fadein_nxt;

  logic [AW-1:0] res_alpha_r, res_alpha_nxt;
  logic          res_upd_r, res_upd_nxt;
  logic          res_act_r, res_act_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [AW-1:0] out_alpha_r, out_alpha_nxt;
  logic          out_upd_r, out_upd_nxt;
  logic          out_act_r, out_act_nxt;

  fdramp_pkg::alu_req_t alu_req;
  fdramp_pkg::alu_res_t alu_res;

  fdramp_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  logic [RW-1:0] f4;
  logic [RW-1:0] d4;
  logic [AW-1:0] held_alpha;
  logic          fin_en;
  logic          fin_stop;
  logic [AW-1:0] fin_alpha;
  logic          div_bit;

  assign f4         = {fade_time_r, 2'b00};
  assign d4         = {darken_time_r, 2'b00};
  assign held_alpha = (last_alpha_r == fdramp_pkg::NO_ALPHA) ? fdramp_pkg::ALPHA_MIN
                                                            : last_alpha_r[AW-1:0];
  assign div_bit    = ~alu_res.borrow;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fdramp_pkg::ST_IDLE;
      running_r    <= 1'b0;
      elapsed_r    <= '0;
      last_alpha_r <= fdramp_pkg::NO_ALPHA;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      running_r    <= running_nxt;
      elapsed_r    <= elapsed_nxt;
      last_alpha_r <= last_alpha_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    delta_r     <= delta_nxt;
    ramp_r      <= ramp_nxt;
    acc_r       <= acc_nxt;
    num_r       <= num_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    q_r         <= q_nxt;
    cnt_r       <= cnt_nxt;
    fadein_r    <= fadein_nxt;
    res_alpha_r <= res_alpha_nxt;
    res_upd_r   <= res_upd_nxt;
    res_act_r   <= res_act_nxt;
    out_alpha_r <= out_alpha_nxt;
    out_upd_r   <= out_upd_nxt;
    out_act_r   <= out_act_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    running_nxt    = running_r;
    elapsed_nxt    = elapsed_r;
    last_alpha_nxt = last_alpha_r;
    delta_nxt      = delta_r;
    ramp_nxt       = ramp_r;
    acc_nxt        = acc_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    q_nxt          = q_r;
    cnt_nxt        = cnt_r;
    fadein_nxt     = fadein_r;
    res_alpha_nxt  = res_alpha_r;
    res_upd_nxt    = res_upd_r;
    res_act_nxt    = res_act_r;
    out_valid_nxt  = out_valid_r;
    out_alpha_nxt  = out_alpha_r;
    out_upd_nxt    = out_upd_r;
    out_act_nxt    = out_act_r;
    alu_req        = '0;
    fin_en         = 1'b0;
    fin_stop       = 1'b0;
    fin_alpha      = fdramp_pkg::ALPHA_MIN;
    in_stall       = (state_r != fdramp_pkg::ST_IDLE);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      fdramp_pkg::ST_IDLE: begin
        if (in_valid) begin
          delta_nxt = in_delta_ticks;
          if (in_req_type == fdramp_pkg::REQ_START) begin
            elapsed_nxt    = '0;
            running_nxt    = 1'b1;
            last_alpha_nxt = fdramp_pkg::NO_ALPHA;
            state_nxt      = fdramp_pkg::ST_RAMP;
          end else if (!running_r) begin
            fin_stop = 1'b1;
          end else begin
            state_nxt = fdramp_pkg::ST_ELAP;
          end
        end
      end

      fdramp_pkg::ST_ELAP: begin
        alu_req.a = UW'(elapsed_r);
        alu_req.b = UW'({delta_r, 2'b00});
        // saturate at all ones, which lies beyond every total
        if (|alu_res.val[UW-1:EW]) begin
          elapsed_nxt = '1;
        end else begin
          elapsed_nxt = alu_res.val[EW-1:0];
        end
        state_nxt = fdramp_pkg::ST_RAMP;
      end

      fdramp_pkg::ST_RAMP: begin
        alu_req.a = UW'(fade_time_r);
        alu_req.b = UW'({fade_time_r, 1'b0});
        ramp_nxt  = alu_res.val[RW-1:0];
        state_nxt = fdramp_pkg::ST_TOT;
      end

      fdramp_pkg::ST_TOT: begin
        unique case (fade_mode_r)
          fdramp_pkg::MODE_IN: begin
            alu_req.a = UW'(f4);
          end
          fdramp_pkg::MODE_OUT: begin
            alu_req.a = UW'(f4);
            alu_req.b = UW'(d4);
          end
          fdramp_pkg::MODE_OUTIN: begin
            alu_req.a = UW'({f4, 1'b0});
            alu_req.b = UW'(d4);
          end
          fdramp_pkg::MODE_NONE: ;
          default: ;
        endcase
        acc_nxt   = alu_res.val[EW-1:0];
        state_nxt = fdramp_pkg::ST_CMP;
      end

      fdramp_pkg::ST_CMP: begin
        alu_req.a   = UW'(acc_r);
        alu_req.b   = UW'(elapsed_r);
        alu_req.sub = 1'b1;
        fadein_nxt  = 1'b0;
        if (alu_res.borrow) begin
          // elapsed passed the total: fade is over
          running_nxt = 1'b0;
          fin_stop    = 1'b1;
        end else begin
          unique case (fade_mode_r)
            fdramp_pkg::MODE_IN: begin
              acc_nxt   = elapsed_r;
              state_nxt = fdramp_pkg::ST_NUM;
            end
            fdramp_pkg::MODE_OUT: begin
              num_nxt   = elapsed_r;
              state_nxt = fdramp_pkg::ST_CLAMP;
            end
            fdramp_pkg::MODE_OUTIN: begin
              state_nxt = fdramp_pkg::ST_PH1;
            end
            fdramp_pkg::MODE_NONE: begin
              fin_en    = 1'b1;
              fin_alpha = fdramp_pkg::ALPHA_MIN;
            end
            default: ;
          endcase
        end
      end

      fdramp_pkg::ST_PH1: begin
        alu_req.a   = UW'(elapsed_r);
        alu_req.b   = UW'(f4);
        alu_req.sub = 1'b1;
        if (alu_res.borrow) begin
          num_nxt   = elapsed_r;
          state_nxt = fdramp_pkg::ST_CLAMP;
        end else begin
          acc_nxt   = alu_res.val[EW-1:0];
          state_nxt = fdramp_pkg::ST_PH2;
        end
      end

      fdramp_pkg::ST_PH2: begin
        alu_req.a   = UW'(acc_r);
        alu_req.b   = UW'(d4);
        alu_req.sub = 1'b1;
        if (alu_res.borrow) begin
          // dark hold
          fin_en    = 1'b1;
          fin_alpha = fdramp_pkg::ALPHA_MAX;
        end else begin
          acc_nxt   = alu_res.val[EW-1:0];
          state_nxt = fdramp_pkg::ST_NUM;
        end
      end

      fdramp_pkg::ST_NUM: begin
        // fade-in part: num = 4F - time into the phase, never negative here
        alu_req.a   = UW'(f4);
        alu_req.b   = UW'(acc_r);
        alu_req.sub = 1'b1;
        num_nxt     = alu_res.val[EW-1:0];
        fadein_nxt  = 1'b1;
        state_nxt   = fdramp_pkg::ST_CLAMP;
      end

      fdramp_pkg::ST_CLAMP: begin
        alu_req.a   = UW'(num_r);
        alu_req.b   = UW'(ramp_r);
        alu_req.sub = 1'b1;
        if (ramp_r == '0) begin
          fin_en    = 1'b1;
          fin_alpha = fadein_r ? fdramp_pkg::ALPHA_MAX : fdramp_pkg::ALPHA_MIN;
        end else if (!alu_res.borrow) begin
          fin_en    = 1'b1;
          fin_alpha = fdramp_pkg::ALPHA_MAX;
        end else if (num_r == '0) begin
          fin_en    = 1'b1;
          fin_alpha = fdramp_pkg::ALPHA_MIN;
        end else begin
          state_nxt = fdramp_pkg::ST_MUL;
        end
      end

      fdramp_pkg::ST_MUL: begin
        // 255*num as (num << 8) - num; num < ramp here
        alu_req.a   = UW'({num_r[RW-1:0], {AW{1'b0}}});
        alu_req.b   = UW'(num_r[RW-1:0]);
        alu_req.sub = 1'b1;
        rem_nxt     = alu_res.val[XW-1:0];
        div_nxt     = {ramp_r, {(AW-1){1'b0}}};
        q_nxt       = '0;
        cnt_nxt     = CW'(AW - 1);
        state_nxt   = fdramp_pkg::ST_DIV;
      end

      fdramp_pkg::ST_DIV: begin
        // restoring divide, one quotient bit per cycle, msb first
        alu_req.a   = UW'(rem_r);
        alu_req.b   = UW'(div_r);
        alu_req.sub = 1'b1;
        if (div_bit) begin
          rem_nxt = alu_res.val[XW-1:0];
        end
        q_nxt   = {q_r[AW-3:0], div_bit};
        div_nxt = div_r >> 1;
        if (cnt_r == '0) begin
          fin_en    = 1'b1;
          fin_alpha = {q_r, div_bit};
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end

      fdramp_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_alpha_nxt = res_alpha_r;
          out_upd_nxt   = res_upd_r;
          out_act_nxt   = res_act_r;
          state_nxt     = fdramp_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = fdramp_pkg::ST_IDLE;
      end
    endcase

    if (fin_stop) begin
      res_alpha_nxt = held_alpha;
      res_upd_nxt   = 1'b0;
      res_act_nxt   = 1'b0;
      state_nxt     = fdramp_pkg::ST_DONE;
    end else if (fin_en) begin
      res_alpha_nxt  = fin_alpha;
      res_upd_nxt    = ({1'b0, fin_alpha} != last_alpha_r);
      res_act_nxt    = 1'b1;
      last_alpha_nxt = {1'b0, fin_alpha};
      state_nxt      = fdramp_pkg::ST_DONE;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_alpha         = out_alpha_r;
  assign out_alpha_updated = out_upd_r;
  assign out_active        = out_act_r;

  `FDR_ASSERT_NEXT(a_done_loads_out, (state_r == fdramp_pkg::ST_DONE) && (!out_valid_r || !out_stall), out_valid && (state_r == fdramp_pkg::ST_IDLE), "result not loaded into output register")
  `FDR_ASSERT_NOW(a_active_needs_running, (state_r == fdramp_pkg::ST_DONE) && res_act_r, running_r, "active result while not running")
  `FDR_ASSERT_NOW(a_div_nonzero_ramp, (state_r == fdramp_pkg::ST_DIV), ramp_r != '0, "divide step with zero ramp")
  `FDR_ASSERT_NOW(a_inactive_no_update, out_valid && !out_active, !out_alpha_updated, "update flagged on inactive transaction")

endmodule

`default_nettype wire
